>>> src/wcar_pkg.sv
// Package for the water coverage alpha rasterizer: constants, register indexes,
// status codes, the control state type, two data types and a small helper function.
// No dependencies; every file that uses it refers to it by scoped names.
package wcar_pkg;

    localparam int MAP_BITS   = 7;
    localparam int MAP_SIDE   = 1 << MAP_BITS;
    localparam int MAP_DEPTH  = MAP_SIDE * MAP_SIDE;
    localparam int ADDR_BITS  = 2 * MAP_BITS;
    localparam int CAT_WIDTH  = 8;
    localparam int UNIT_Q8    = 256;
    localparam int HALF_AREA  = (UNIT_Q8 * UNIT_Q8) / 2;
    localparam int BIAS_ROUND = 16384;
    localparam int BIAS_SHIFT = 15;

    localparam logic [3:0] SADDLE_A = 4'd5;
    localparam logic [3:0] SADDLE_B = 4'd10;

    localparam logic [2:0] CFG_MAP_WIDTH  = 3'd0;
    localparam logic [2:0] CFG_MAP_HEIGHT = 3'd1;
    localparam logic [2:0] CFG_SCALE      = 3'd2;
    localparam logic [2:0] CFG_SUBSAMPLE  = 3'd3;
    localparam logic [2:0] CFG_LAND       = 3'd4;
    localparam logic [2:0] CFG_OCEAN      = 3'd5;
    localparam logic [2:0] CFG_LAKE       = 3'd6;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_BAD_CFG = 2'd1;
    localparam logic [1:0] STATUS_OUTSIDE = 2'd2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_PIX,
        S_SAMP,
        S_CRD,
        S_MUL,
        S_EVAL,
        S_BAL,
        S_ACC,
        S_RAW,
        S_FEA,
        S_CAT,
        S_OUT
    } t_state;

    typedef logic [8:0][7:0] t_alpha9;

    typedef struct packed {
        logic [MAP_BITS-1:0] tile;
        logic [7:0]          frac;
    } t_loc;

    // Index of the highest set bit of an 8-bit value (its log2 when it is a power of two).
    function automatic logic [2:0] log2_8(input logic [7:0] v);
        logic [2:0] r;
        r = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (v[i]) begin
                r = 3'(i);
            end
        end
        return r;
    endfunction

endpackage

>>> src/wcar_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// No dependencies.
module wcar_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/wcar_feather.sv
// Feather filter for one class: 1-2-1 by 1-2-1 smoothing of a 3x3 alpha window.
// Depends on wcar_pkg for the window type.
module wcar_feather (
    input  wcar_pkg::t_alpha9 i_alpha,
    input  logic              i_core,
    output logic [7:0]        o_alpha
);

    logic [7:0]  c;
    logic        partial;
    logic        differs;
    logic [12:0] sum;

    always_comb begin
        c       = i_alpha[4];
        partial = (c != 8'd0) && (c != 8'd255);
        differs = 1'b0;
        for (int i = 0; i < 9; i++) begin
            if (i_alpha[i] != c) begin
                differs = 1'b1;
            end
        end
        sum = 13'(i_alpha[0]) + (13'(i_alpha[1]) << 1) + 13'(i_alpha[2])
            + (13'(i_alpha[3]) << 1) + (13'(i_alpha[4]) << 2) + (13'(i_alpha[5]) << 1)
            + 13'(i_alpha[6]) + (13'(i_alpha[7]) << 1) + 13'(i_alpha[8]) + 13'd8;
        if (!partial && (i_core || !differs)) begin
            o_alpha = c;
        end else begin
            o_alpha = 8'(sum >> 4);
        end
    end

endmodule

>>> src/water_coverage_alpha_rasterizer_top.sv
// Top level of the water coverage alpha rasterizer: control sequencer, shared
// multiplier, sample counters and the tile map. Depends on wcar_pkg, wcar_ram, wcar_feather.
//
//   Channel   Direction  Handshake                     Payload
//   request   in         i_in_valid / o_in_ready       i_op, i_tile_*, i_pixel_*
//   result    out        o_out_valid / i_out_ready     o_*_alpha, flags, o_status
//   config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// A load request writes the tile map in the cycle it is accepted.
// A query walks nine neighbor pixels, each over n*n subsamples (n = subsample_count);
// a subsample takes one map read per corner and seven passes of the shared multiplier,
// plus the 4x4 balance window when a water saddle needs it, all through the single
// read port of the tile map. A rejected query skips the walk and goes straight to the result.
// Reset is synchronous and active low; the tile map is not cleared.
// A finished result waits in the output register; loads are still accepted then.
module water_coverage_alpha_rasterizer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_op,
    input  logic [6:0]  i_tile_col,
    input  logic [6:0]  i_tile_row,
    input  logic [7:0]  i_tile_category,
    input  logic [13:0] i_pixel_col,
    input  logic [13:0] i_pixel_row,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_ocean_alpha,
    output logic [7:0]  o_lake_alpha,
    output logic        o_ocean_rejected,
    output logic        o_lake_rejected,
    output logic        o_overlap_removed,
    output logic [1:0]  o_status,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);

    localparam int AW = wcar_pkg::ADDR_BITS;
    localparam int MB = wcar_pkg::MAP_BITS;

    wcar_pkg::t_state r_state, n_state;

    // Configuration registers.
    logic [7:0] r_mw, r_mh, r_scale, r_sub, r_land, r_ocean_code, r_lake_code;

    // Query context.
    logic [13:0] r_px, r_py, r_nx, r_ny;
    logic [2:0]  r_ls, r_lk;
    logic [1:0]  r_status;
    logic [1:0]  r_dx, r_dy;
    logic [3:0]  r_pix;
    logic [6:0]  r_sx, r_sy;
    logic [MB-1:0] r_cx, r_cy;
    logic [7:0]  r_fx, r_fy;
    logic [2:0]  r_k, r_m;
    logic [3:0]  r_wcode, r_lcode;
    logic [16:0] r_pa, r_pb, r_pc, r_pd;
    logic [14:0] r_gx, r_gy;
    logic [28:0] r_p;
    logic [13:0] r_bias;
    logic [4:0]  r_bi, r_bal_in, r_bal_n;
    logic        r_bal_iss;
    logic [14:0] r_cnt_o, r_cnt_l;
    wcar_pkg::t_alpha9 r_ao, r_al;
    logic [7:0]  r_fo, r_fl, r_cat;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_o_ocean, r_o_lake;
    logic        r_o_orej, r_o_lrej, r_o_ovl;
    logic [1:0]  r_o_status;

    // Tile map port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_rdata;

    logic accept_in;
    logic out_free;

    assign o_in_ready = (r_state == wcar_pkg::S_IDLE);
    assign accept_in  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign ram_we     = accept_in && (i_op == wcar_pkg::OP_LOAD);
    assign ram_waddr  = {i_tile_row, i_tile_col};

    wcar_ram #(
        .WIDTH(wcar_pkg::CAT_WIDTH),
        .DEPTH(wcar_pkg::MAP_DEPTH)
    ) u_map (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(i_tile_category),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // Maps a Q8 coordinate onto a map cell and its fraction, snapping outside the map.
    function automatic wcar_pkg::t_loc locate(input logic signed [22:0] c,
                                              input logic [7:0] lim);
        wcar_pkg::t_loc r;
        logic [7:0] lm1;
        lm1 = lim - 8'd1;
        if (c <= 23'sd0 || lim <= 8'd1) begin
            r.tile = '0;
            r.frac = '0;
        end else if (c >= $signed({7'b0, lm1, 8'b0})) begin
            r.tile = lm1[MB-1:0];
            r.frac = '0;
        end else begin
            r.tile = c[MB+7:8];
            r.frac = c[7:0];
        end
        return r;
    endfunction

    // The setting is legal only when scale and subsample count are powers of two
    // whose product divides the Q8 unit, so every division below is a shift.
    logic [2:0]  ls_c, lk_c;
    logic        cfg_ok;
    logic [14:0] w_c, h_c;
    always_comb begin
        ls_c   = wcar_pkg::log2_8(r_scale);
        lk_c   = wcar_pkg::log2_8(r_sub);
        cfg_ok = (r_mw != 8'd0) && (r_mw <= 8'(wcar_pkg::MAP_SIDE))
              && (r_mh != 8'd0) && (r_mh <= 8'(wcar_pkg::MAP_SIDE))
              && (r_scale >= 8'd2) && ((r_scale & (r_scale - 8'd1)) == 8'd0)
              && (r_sub != 8'd0) && ((r_sub & (r_sub - 8'd1)) == 8'd0)
              && ((4'(ls_c) + 4'(lk_c)) <= 4'd8);
        w_c = 15'(r_mw) << ls_c;
        h_c = 15'(r_mh) << ls_c;
    end

    // Image size with the latched scale, and the clamped neighbor pixel.
    logic [14:0]        w_m1, h_m1;
    logic signed [16:0] nx_s, ny_s;
    logic [13:0]        nx_c, ny_c;
    always_comb begin
        w_m1 = (15'(r_mw) << r_ls) - 15'd1;
        h_m1 = (15'(r_mh) << r_ls) - 15'd1;
        nx_s = $signed({3'b0, r_px}) + $signed({15'b0, r_dx}) - 17'sd1;
        ny_s = $signed({3'b0, r_py}) + $signed({15'b0, r_dy}) - 17'sd1;
        if (nx_s < 17'sd0) begin
            nx_c = '0;
        end else if (nx_s > $signed({2'b0, w_m1})) begin
            nx_c = w_m1[13:0];
        end else begin
            nx_c = nx_s[13:0];
        end
        if (ny_s < 17'sd0) begin
            ny_c = '0;
        end else if (ny_s > $signed({2'b0, h_m1})) begin
            ny_c = h_m1[13:0];
        end else begin
            ny_c = ny_s[13:0];
        end
    end

    // Subsample coordinates in Q8 tile units.
    logic [3:0]         pix_sh, step_sh;
    logic [21:0]        half_step, xbase, ybase;
    logic signed [22:0] xq, yq;
    wcar_pkg::t_loc     loc_x, loc_y;
    always_comb begin
        pix_sh    = 4'd8 - 4'(r_ls);
        step_sh   = 4'd8 - 4'(r_ls) - 4'(r_lk);
        half_step = 22'((9'd1 << step_sh) >> 1);
        xbase     = (22'(r_nx) << pix_sh) + (22'(r_sx) << step_sh) + half_step;
        ybase     = (22'(r_ny) << pix_sh) + (22'(r_sy) << step_sh) + half_step;
        xq        = $signed({1'b0, xbase}) - 23'sd128;
        yq        = $signed({1'b0, ybase}) - 23'sd128;
        loc_x     = locate(xq, r_mw);
        loc_y     = locate(yq, r_mh);
    end

    // Corner and balance-window addresses; corners clamp to the last tile.
    logic [MB-1:0]     x1, y1;
    logic [AW-1:0]     corner_addr;
    logic signed [8:0] bx, by;
    logic              b_in_map;
    always_comb begin
        x1 = (8'(r_cx) == r_mw - 8'd1) ? r_cx : r_cx + MB'(1);
        y1 = (8'(r_cy) == r_mh - 8'd1) ? r_cy : r_cy + MB'(1);
        case (r_k[1:0])
            2'd0:    corner_addr = {r_cy, r_cx};
            2'd1:    corner_addr = {r_cy, x1};
            2'd2:    corner_addr = {y1, x1};
            default: corner_addr = {y1, r_cx};
        endcase
        bx = $signed({2'b0, r_cx}) + $signed({7'b0, r_bi[1:0]}) - 9'sd1;
        by = $signed({2'b0, r_cy}) + $signed({7'b0, r_bi[3:2]}) - 9'sd1;
        b_in_map = (bx >= 9'sd0) && (bx < $signed({1'b0, r_mw}))
                && (by >= 9'sd0) && (by < $signed({1'b0, r_mh}))
                && !r_bi[4];
    end

    always_comb begin
        case (r_state)
            wcar_pkg::S_CRD: ram_raddr = corner_addr;
            wcar_pkg::S_BAL: ram_raddr = {by[MB-1:0], bx[MB-1:0]};
            wcar_pkg::S_FEA: ram_raddr = {7'(r_py >> r_ls), 7'(r_px >> r_ls)};
            default:         ram_raddr = '0;
        endcase
    end

    // Shared multiplier: bilinear weights, then the saddle bias product.
    logic [8:0]  ix, iy;
    logic [14:0] mul_a, mul_b;
    logic [29:0] mul_p;
    always_comb begin
        ix = 9'd256 - 9'(r_fx);
        iy = 9'd256 - 9'(r_fy);
        case (r_m)
            3'd0:    begin mul_a = 15'(ix);   mul_b = 15'(iy);   end
            3'd1:    begin mul_a = 15'(r_fx); mul_b = 15'(iy);   end
            3'd2:    begin mul_a = 15'(r_fx); mul_b = 15'(r_fy); end
            3'd3:    begin mul_a = 15'(ix);   mul_b = 15'(r_fy); end
            3'd4:    begin mul_a = 15'(r_fx); mul_b = 15'(ix);   end
            3'd5:    begin mul_a = 15'(r_fy); mul_b = 15'(iy);   end
            default: begin mul_a = r_gx;      mul_b = r_gy;      end
        endcase
        mul_p = 30'(mul_a) * 30'(mul_b);
    end

    // Saddle bias and the per-class inside test.
    logic [14:0]        bias_c;
    logic               saddle;
    logic [18:0]        base_w, base_l;
    logic signed [19:0] s_w, s_l;
    logic               in_w, in_l;
    always_comb begin
        bias_c = 15'((30'(r_p) + 30'(wcar_pkg::BIAS_ROUND)) >> wcar_pkg::BIAS_SHIFT);
        saddle = (r_wcode == wcar_pkg::SADDLE_A) || (r_wcode == wcar_pkg::SADDLE_B);
        base_w = (r_wcode[0] ? 19'(r_pa) : 19'd0) + (r_wcode[1] ? 19'(r_pb) : 19'd0)
               + (r_wcode[2] ? 19'(r_pc) : 19'd0) + (r_wcode[3] ? 19'(r_pd) : 19'd0);
        base_l = (r_lcode[0] ? 19'(r_pa) : 19'd0) + (r_lcode[1] ? 19'(r_pb) : 19'd0)
               + (r_lcode[2] ? 19'(r_pc) : 19'd0) + (r_lcode[3] ? 19'(r_pd) : 19'd0);
        s_w = $signed({1'b0, base_w});
        // The bias is only nonzero when a balance window is read for this subsample.
        if (r_bias != 14'd0) begin
            if ({r_bal_in, 1'b0} > 6'(r_bal_n)) begin
                s_w = s_w + $signed({6'b0, r_bias});
            end else if ({r_bal_in, 1'b0} < 6'(r_bal_n)) begin
                s_w = s_w - $signed({6'b0, r_bias});
            end
        end
        s_l  = $signed({1'b0, base_l});
        in_w = s_w >= 20'(wcar_pkg::HALF_AREA);
        in_l = s_l >= 20'(wcar_pkg::HALF_AREA);
    end

    // Raw alpha of a finished pixel: (count*255 + total/2) / total with total = 4^lk.
    logic [3:0]  tot_sh;
    logic [22:0] half_tot;
    logic [7:0]  raw_o, raw_l;
    logic [6:0]  n_m1;
    always_comb begin
        tot_sh   = {r_lk, 1'b0};
        half_tot = (23'd1 << tot_sh) >> 1;
        raw_o    = 8'((((23'(r_cnt_o) << 8) - 23'(r_cnt_o)) + half_tot) >> tot_sh);
        raw_l    = 8'((((23'(r_cnt_l) << 8) - 23'(r_cnt_l)) + half_tot) >> tot_sh);
        n_m1     = 7'(r_sub - 8'd1);
    end

    // Feathering; the core is the 2x2 pixel block at the center of a tile.
    logic [7:0] tx, ty, half_s;
    logic       core;
    logic [7:0] fea_o, fea_l;
    always_comb begin
        tx     = r_px[7:0] & (r_scale - 8'd1);
        ty     = r_py[7:0] & (r_scale - 8'd1);
        half_s = r_scale >> 1;
        core   = (tx == half_s - 8'd1 || tx == half_s) && (ty == half_s - 8'd1 || ty == half_s);
    end

    wcar_feather u_fea_ocean (.i_alpha(r_ao), .i_core(core), .o_alpha(fea_o));
    wcar_feather u_fea_lake  (.i_alpha(r_al), .i_core(core), .o_alpha(fea_l));

    // Final class masking and overlap removal.
    logic [7:0] fin_o, fin_l;
    logic       fin_orej, fin_lrej, fin_ovl;
    always_comb begin
        fin_o    = r_fo;
        fin_l    = r_fl;
        fin_orej = 1'b0;
        fin_lrej = 1'b0;
        fin_ovl  = 1'b0;
        if (r_cat != r_ocean_code) begin
            fin_orej = (fin_o != 8'd0);
            fin_o    = 8'd0;
        end
        if (r_cat != r_lake_code) begin
            fin_lrej = (fin_l != 8'd0);
            fin_l    = 8'd0;
        end else if (fin_l != 8'd0 && fin_o != 8'd0) begin
            fin_o   = 8'd0;
            fin_ovl = 1'b1;
        end
        if (r_status != wcar_pkg::STATUS_OK) begin
            fin_o    = 8'd0;
            fin_l    = 8'd0;
            fin_orej = 1'b0;
            fin_lrej = 1'b0;
            fin_ovl  = 1'b0;
        end
    end

    // Next state of the sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            wcar_pkg::S_IDLE: begin
                if (accept_in && i_op != wcar_pkg::OP_LOAD) begin
                    n_state = wcar_pkg::S_CHECK;
                end
            end
            wcar_pkg::S_CHECK: begin
                if (!cfg_ok || 15'(r_px) >= w_c || 15'(r_py) >= h_c) begin
                    n_state = wcar_pkg::S_OUT;
                end else begin
                    n_state = wcar_pkg::S_PIX;
                end
            end
            wcar_pkg::S_PIX:  n_state = wcar_pkg::S_SAMP;
            wcar_pkg::S_SAMP: n_state = wcar_pkg::S_CRD;
            wcar_pkg::S_CRD: begin
                if (r_k == 3'd4) begin
                    n_state = wcar_pkg::S_MUL;
                end
            end
            wcar_pkg::S_MUL: begin
                if (r_m == 3'd6) begin
                    n_state = wcar_pkg::S_EVAL;
                end
            end
            wcar_pkg::S_EVAL: begin
                if (saddle && bias_c != 15'd0) begin
                    n_state = wcar_pkg::S_BAL;
                end else begin
                    n_state = wcar_pkg::S_ACC;
                end
            end
            wcar_pkg::S_BAL: begin
                if (r_bi[4]) begin
                    n_state = wcar_pkg::S_ACC;
                end
            end
            wcar_pkg::S_ACC: begin
                if (r_sx == n_m1 && r_sy == n_m1) begin
                    n_state = wcar_pkg::S_RAW;
                end else begin
                    n_state = wcar_pkg::S_SAMP;
                end
            end
            wcar_pkg::S_RAW: begin
                if (r_pix == 4'd8) begin
                    n_state = wcar_pkg::S_FEA;
                end else begin
                    n_state = wcar_pkg::S_PIX;
                end
            end
            wcar_pkg::S_FEA: n_state = wcar_pkg::S_CAT;
            wcar_pkg::S_CAT: n_state = wcar_pkg::S_OUT;
            wcar_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = wcar_pkg::S_IDLE;
                end
            end
            default: n_state = wcar_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wcar_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mw         <= 8'd1;
            r_mh         <= 8'd1;
            r_scale      <= 8'd2;
            r_sub        <= 8'd1;
            r_land       <= 8'd0;
            r_ocean_code <= 8'd1;
            r_lake_code  <= 8'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                wcar_pkg::CFG_MAP_WIDTH:  r_mw         <= i_cfg_data;
                wcar_pkg::CFG_MAP_HEIGHT: r_mh         <= i_cfg_data;
                wcar_pkg::CFG_SCALE:      r_scale      <= i_cfg_data;
                wcar_pkg::CFG_SUBSAMPLE:  r_sub        <= i_cfg_data;
                wcar_pkg::CFG_LAND:       r_land       <= i_cfg_data;
                wcar_pkg::CFG_OCEAN:      r_ocean_code <= i_cfg_data;
                wcar_pkg::CFG_LAKE:       r_lake_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Datapath registers, stepped by the sequencer. Only one request is in flight,
    // so map writes (idle only) never overlap the reads of a query.
    always_ff @(posedge i_clk) begin
        case (r_state)
            wcar_pkg::S_IDLE: begin
                if (accept_in) begin
                    r_px <= i_pixel_col;
                    r_py <= i_pixel_row;
                end
            end
            wcar_pkg::S_CHECK: begin
                r_ls  <= ls_c;
                r_lk  <= lk_c;
                r_dx  <= 2'd0;
                r_dy  <= 2'd0;
                r_pix <= 4'd0;
                if (!cfg_ok) begin
                    r_status <= wcar_pkg::STATUS_BAD_CFG;
                end else if (15'(r_px) >= w_c || 15'(r_py) >= h_c) begin
                    r_status <= wcar_pkg::STATUS_OUTSIDE;
                end else begin
                    r_status <= wcar_pkg::STATUS_OK;
                end
            end
            wcar_pkg::S_PIX: begin
                r_nx    <= nx_c;
                r_ny    <= ny_c;
                r_sx    <= 7'd0;
                r_sy    <= 7'd0;
                r_cnt_o <= 15'd0;
                r_cnt_l <= 15'd0;
            end
            wcar_pkg::S_SAMP: begin
                r_cx <= loc_x.tile;
                r_fx <= loc_x.frac;
                r_cy <= loc_y.tile;
                r_fy <= loc_y.frac;
                r_k  <= 3'd0;
            end
            wcar_pkg::S_CRD: begin
                if (r_k != 3'd0) begin
                    r_wcode[2'(r_k - 3'd1)] <= (ram_rdata != r_land);
                    r_lcode[2'(r_k - 3'd1)] <= (ram_rdata == r_lake_code);
                end
                r_k <= r_k + 3'd1;
                r_m <= 3'd0;
            end
            wcar_pkg::S_MUL: begin
                case (r_m)
                    3'd0:    r_pa <= mul_p[16:0];
                    3'd1:    r_pb <= mul_p[16:0];
                    3'd2:    r_pc <= mul_p[16:0];
                    3'd3:    r_pd <= mul_p[16:0];
                    3'd4:    r_gx <= mul_p[14:0];
                    3'd5:    r_gy <= mul_p[14:0];
                    default: r_p  <= mul_p[28:0];
                endcase
                r_m <= r_m + 3'd1;
            end
            wcar_pkg::S_EVAL: begin
                r_bi      <= 5'd0;
                r_bal_in  <= 5'd0;
                r_bal_n   <= 5'd0;
                r_bal_iss <= 1'b0;
                if (saddle) begin
                    r_bias <= bias_c[13:0];
                end else begin
                    r_bias <= 14'd0;
                end
            end
            wcar_pkg::S_BAL: begin
                r_bal_iss <= b_in_map;
                if (b_in_map) begin
                    r_bal_n <= r_bal_n + 5'd1;
                end
                if (r_bal_iss && ram_rdata != r_land) begin
                    r_bal_in <= r_bal_in + 5'd1;
                end
                r_bi <= r_bi + 5'd1;
            end
            wcar_pkg::S_ACC: begin
                r_cnt_o <= r_cnt_o + 15'(in_w);
                r_cnt_l <= r_cnt_l + 15'(in_l);
                if (r_sx == n_m1) begin
                    r_sx <= 7'd0;
                    r_sy <= r_sy + 7'd1;
                end else begin
                    r_sx <= r_sx + 7'd1;
                end
            end
            wcar_pkg::S_RAW: begin
                r_ao[r_pix] <= raw_o;
                r_al[r_pix] <= raw_l;
                r_pix       <= r_pix + 4'd1;
                if (r_dx == 2'd2) begin
                    r_dx <= 2'd0;
                    r_dy <= r_dy + 2'd1;
                end else begin
                    r_dx <= r_dx + 2'd1;
                end
            end
            wcar_pkg::S_FEA: begin
                r_fo <= fea_o;
                r_fl <= fea_l;
            end
            wcar_pkg::S_CAT: begin
                r_cat <= ram_rdata;
            end
            default: ;
        endcase
    end

    // Result register: holds one finished result until the consumer takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == wcar_pkg::S_OUT && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == wcar_pkg::S_OUT && out_free) begin
            r_o_ocean  <= fin_o;
            r_o_lake   <= fin_l;
            r_o_orej   <= fin_orej;
            r_o_lrej   <= fin_lrej;
            r_o_ovl    <= fin_ovl;
            r_o_status <= r_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_ocean_alpha     = r_o_ocean;
    assign o_lake_alpha      = r_o_lake;
    assign o_ocean_rejected  = r_o_orej;
    assign o_lake_rejected   = r_o_lrej;
    assign o_overlap_removed = r_o_ovl;
    assign o_status          = r_o_status;

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for water_coverage_alpha_rasterizer_top. It holds a
// behavioral copy of the coverage rasterizer and compares every query result.
// Depends on wcar_pkg and the RTL of the block; reads no files.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    // One expected or observed query result, field for field as on the ports.
    typedef struct packed {
        logic [7:0] ocean;
        logic [7:0] lake;
        logic       ocean_rej;
        logic       lake_rej;
        logic       overlap;
        logic [1:0] status;
    } t_pixel_alpha;

    // The scoreboard keeps its own tile map and register copy, predicts the
    // alpha of every accepted query and compares results in order.
    class coverage_checker;
        byte unsigned tile_map [wcar_pkg::MAP_DEPTH];
        int           map_w, map_h, scale, subs, land, ocean, lake;
        t_pixel_alpha pending_alpha_q [$];
        int           mismatches;

        function new();
            map_w = 1;
            map_h = 1;
            scale = 2;
            subs  = 1;
            land  = 0;
            ocean = 1;
            lake  = 2;
            mismatches = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [7:0] val);
            case (idx)
                wcar_pkg::CFG_MAP_WIDTH:  map_w = val;
                wcar_pkg::CFG_MAP_HEIGHT: map_h = val;
                wcar_pkg::CFG_SCALE:      scale = val;
                wcar_pkg::CFG_SUBSAMPLE:  subs  = val;
                wcar_pkg::CFG_LAND:       land  = val;
                wcar_pkg::CFG_OCEAN:      ocean = val;
                wcar_pkg::CFG_LAKE:       lake  = val;
                default: ;
            endcase
        endfunction

        function int clampi(int v, int lo, int hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function int tile_at(int x, int y);
            x = clampi(x, 0, map_w - 1);
            y = clampi(y, 0, map_h - 1);
            return tile_map[y * wcar_pkg::MAP_SIDE + x];
        endfunction

        // Class 0 is water (anything but land), class 1 is lake.
        function int member(int cls, int x, int y);
            int c;
            c = tile_at(x, y);
            if (cls == 0) return (c != land) ? 1 : 0;
            return (c == lake) ? 1 : 0;
        endfunction

        function void locate(int c, int lim, output int tile, output int frac);
            if (c <= 0 || lim <= 1) begin
                tile = 0;
                frac = 0;
            end else if (c >= (lim - 1) * wcar_pkg::UNIT_Q8) begin
                tile = lim - 1;
                frac = 0;
            end else begin
                tile = c / wcar_pkg::UNIT_Q8;
                frac = c % wcar_pkg::UNIT_Q8;
            end
        endfunction

        // Water tiles minus other tiles in the 4x4 window around the cell, inside the map only.
        function int balance(int cx, int cy);
            int in_cnt, n, sx, sy;
            in_cnt = 0;
            n = 0;
            for (int dy = -1; dy <= 2; dy++) begin
                for (int dx = -1; dx <= 2; dx++) begin
                    sx = cx + dx;
                    sy = cy + dy;
                    if (sx >= 0 && sy >= 0 && sx < map_w && sy < map_h) begin
                        in_cnt += member(0, sx, sy);
                        n++;
                    end
                end
            end
            return in_cnt * 2 - n;
        endfunction

        function bit sample_inside(int cls, int xq, int yq);
            int cx, cy, fx, fy, s, ix, iy, b;
            logic [3:0] code;
            longint unsigned p;
            locate(xq, map_w, cx, fx);
            locate(yq, map_h, cy, fy);
            code = {member(cls, cx, cy + 1) != 0, member(cls, cx + 1, cy + 1) != 0,
                    member(cls, cx + 1, cy) != 0, member(cls, cx, cy) != 0};
            ix = wcar_pkg::UNIT_Q8 - fx;
            iy = wcar_pkg::UNIT_Q8 - fy;
            s = 0;
            if (code[0]) s += ix * iy;
            if (code[1]) s += fx * iy;
            if (code[2]) s += fx * fy;
            if (code[3]) s += ix * fy;
            // Water saddles lean toward the majority of the surrounding window.
            if (cls == 0 && (code == wcar_pkg::SADDLE_A || code == wcar_pkg::SADDLE_B)) begin
                p = longint'(fx * ix) * longint'(fy * iy);
                b = balance(cx, cy);
                if (b > 0)
                    s += int'((p + wcar_pkg::BIAS_ROUND) >> wcar_pkg::BIAS_SHIFT);
                else if (b < 0)
                    s -= int'((p + wcar_pkg::BIAS_ROUND) >> wcar_pkg::BIAS_SHIFT);
            end
            return s >= wcar_pkg::HALF_AREA;
        endfunction

        function int sub_coord(int pix, int sub);
            int step;
            step = wcar_pkg::UNIT_Q8 / (scale * subs);
            return pix * (wcar_pkg::UNIT_Q8 / scale) + sub * step + step / 2
                   - wcar_pkg::UNIT_Q8 / 2;
        endfunction

        function int raw_alpha(int cls, int px, int py);
            int total, cnt;
            total = subs * subs;
            cnt = 0;
            for (int sy = 0; sy < subs; sy++)
                for (int sx = 0; sx < subs; sx++)
                    cnt += sample_inside(cls, sub_coord(px, sx), sub_coord(py, sy));
            return (cnt * 255 + total / 2) / total;
        endfunction

        function int feathered(int cls, int x, int y, int w, int h);
            int a [3][3];
            int c, sum, tx, ty;
            bit varies, core;
            tx = x % scale;
            ty = y % scale;
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++)
                    a[dy][dx] = raw_alpha(cls, clampi(x + dx - 1, 0, w - 1),
                                          clampi(y + dy - 1, 0, h - 1));
            c = a[1][1];
            varies = c > 0 && c < 255;
            core = (tx == scale / 2 - 1 || tx == scale / 2) &&
                   (ty == scale / 2 - 1 || ty == scale / 2);
            if (!varies && core) return c;
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++)
                    if (a[dy][dx] != c) varies = 1;
            if (!varies) return c;
            sum = 0;
            for (int dy = 0; dy < 3; dy++)
                for (int dx = 0; dx < 3; dx++)
                    sum += a[dy][dx] * (dx == 1 ? 2 : 1) * (dy == 1 ? 2 : 1);
            return (sum + 8) / 16;
        endfunction

        function bit setting_ok();
            int prod;
            prod = scale * subs;
            return !(map_w == 0 || map_h == 0 || map_w > wcar_pkg::MAP_SIDE ||
                     map_h > wcar_pkg::MAP_SIDE || scale < 2 || subs == 0 ||
                     prod > wcar_pkg::UNIT_Q8 || (wcar_pkg::UNIT_Q8 % prod) != 0);
        endfunction

        function t_pixel_alpha predict_pixel(int px, int py);
            t_pixel_alpha r;
            int w, h, cat, oa, la;
            r = '{8'd0, 8'd0, 1'b0, 1'b0, 1'b0, wcar_pkg::STATUS_OK};
            if (!setting_ok()) begin
                r.status = wcar_pkg::STATUS_BAD_CFG;
                return r;
            end
            w = map_w * scale;
            h = map_h * scale;
            if (px >= w || py >= h) begin
                r.status = wcar_pkg::STATUS_OUTSIDE;
                return r;
            end
            cat = tile_at(px / scale, py / scale);
            oa = feathered(0, px, py, w, h);
            la = feathered(1, px, py, w, h);
            if (cat != ocean) begin
                r.ocean_rej = oa != 0;
                oa = 0;
            end
            if (cat != lake) begin
                r.lake_rej = la != 0;
                la = 0;
            end else if (la != 0 && oa != 0) begin
                oa = 0;
                r.overlap = 1'b1;
            end
            r.ocean = oa[7:0];
            r.lake  = la[7:0];
            return r;
        endfunction

        function void note_request(logic op, logic [6:0] tc, logic [6:0] tr,
                                   logic [7:0] cat, logic [13:0] pc, logic [13:0] pr);
            if (op == wcar_pkg::OP_LOAD)
                tile_map[int'(tr) * wcar_pkg::MAP_SIDE + int'(tc)] = cat;
            else
                pending_alpha_q.push_back(predict_pixel(pc, pr));
        endfunction

        function void check_result(t_pixel_alpha got);
            t_pixel_alpha want;
            if (pending_alpha_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result at %0t", $realtime);
                return;
            end
            want = pending_alpha_q.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"mismatch at %0t: expected o=%0d l=%0d or=%b lr=%b ov=%b st=%0d,",
                              " got o=%0d l=%0d or=%b lr=%b ov=%b st=%0d"},
                             $realtime, want.ocean, want.lake, want.ocean_rej,
                             want.lake_rej, want.overlap, want.status, got.ocean, got.lake,
                             got.ocean_rej, got.lake_rej, got.overlap, got.status);
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_op = 1'b0;
    logic [6:0]  i_tile_col = '0;
    logic [6:0]  i_tile_row = '0;
    logic [7:0]  i_tile_category = '0;
    logic [13:0] i_pixel_col = '0;
    logic [13:0] i_pixel_row = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [7:0]  o_ocean_alpha;
    logic [7:0]  o_lake_alpha;
    logic        o_ocean_rejected;
    logic        o_lake_rejected;
    logic        o_overlap_removed;
    logic [1:0]  o_status;
    logic        i_cfg_we = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [7:0]  i_cfg_data = '0;

    coverage_checker checker_h = new();
    bit idle_on = 1'b0;
    bit hold_go = 1'b0;
    bit long_hold = 1'b0;
    int hold_cnt = 0;
    int requests_sent = 0;

    water_coverage_alpha_rasterizer_top DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // One long hold-off of the result side, counted here, so that a finished
    // result blocks the block and the sender backs up.
    initial begin
        wait (hold_go);
        @(posedge i_clk);
        long_hold <= 1'b1;
        repeat (3000) @(posedge i_clk);
        long_hold <= 1'b0;
    end

    // Result side: random stalls per result when gaps are on, and none while the long hold-off runs.
    always @(posedge i_clk) begin
        if (o_out_valid && i_out_ready)
            checker_h.check_result('{o_ocean_alpha, o_lake_alpha, o_ocean_rejected,
                                     o_lake_rejected, o_overlap_removed, o_status});
        if (long_hold) begin
            i_out_ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            i_out_ready <= 1'b0;
        end else if (o_out_valid && i_out_ready && idle_on) begin
            hold_cnt <= $urandom_range(0, 18);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Offers one request and returns once it has been accepted; the valid
    // stays high into the next request when no gap is drawn.
    task automatic send_request(logic op, logic [6:0] tc, logic [6:0] tr,
                                logic [7:0] cat, logic [13:0] pc, logic [13:0] pr);
        int gap;
        gap = idle_on ? $urandom_range(0, 18) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_op <= op;
        i_tile_col <= tc;
        i_tile_row <= tr;
        i_tile_category <= cat;
        i_pixel_col <= pc;
        i_pixel_row <= pr;
        do @(posedge i_clk); while (!o_in_ready);
        checker_h.note_request(op, tc, tr, cat, pc, pr);
        requests_sent++;
    endtask

    task automatic load_tile(int col, int row, int cat);
        send_request(wcar_pkg::OP_LOAD, 7'(col), 7'(row), 8'(cat), 14'($urandom),
                     14'($urandom));
    endtask

    task automatic query_pixel(int col, int row);
        send_request(wcar_pkg::OP_QUERY, 7'($urandom), 7'($urandom), 8'($urandom),
                     14'(col), 14'(row));
    endtask

    // Waits until every result is in, then lets the last load settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (checker_h.pending_alpha_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    // Writes all seven registers back to back while the block is idle.
    task automatic write_settings(int w, int h, int s, int n, int ld, int oc, int lk);
        int vals [7];
        vals = '{w, h, s, n, ld, oc, lk};
        for (int i = 0; i < 7; i++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_data <= 8'(vals[i]);
            @(posedge i_clk);
            checker_h.write_reg(3'(i), 8'(vals[i]));
        end
        i_cfg_we <= 1'b0;
    endtask

    // A category drawn mostly from the three meaningful codes.
    function automatic int pick_category();
        case ($urandom_range(0, 4))
            0: return checker_h.land;
            1: return checker_h.ocean;
            2: return checker_h.lake;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // Every tile of the used map is written before any query may read it.
    task automatic fill_map();
        for (int r = 0; r < checker_h.map_h; r++)
            for (int c = 0; c < checker_h.map_w; c++)
                load_tile(c, r, pick_category());
    endtask

    task automatic random_query();
        if ($urandom_range(0, 9) == 0)
            query_pixel($urandom_range(0, 16383), $urandom_range(0, 16383));
        else
            query_pixel($urandom_range(0, checker_h.map_w * checker_h.scale - 1),
                        $urandom_range(0, checker_h.map_h * checker_h.scale - 1));
    endtask

    initial begin
        int w, h, s, n, items;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: five invalid settings, checked before the map is read.
        write_settings(0, 1, 2, 1, 0, 1, 2);
        query_pixel(0, 0);
        drain();
        write_settings(200, 1, 1, 1, 0, 1, 2);
        query_pixel(0, 0);
        drain();
        write_settings(1, 0, 2, 0, 0, 1, 2);
        query_pixel(0, 0);
        drain();
        write_settings(1, 1, 3, 1, 0, 1, 2);
        query_pixel(0, 0);
        drain();
        write_settings(1, 1, 4, 128, 0, 1, 2);
        query_pixel(0, 0);
        drain();

        // Directed: a water saddle (ocean on one diagonal, land on the other)
        // with a lake tile, queried at corners, centre and just past the edges.
        write_settings(3, 2, 4, 2, 0, 1, 2);
        load_tile(0, 0, 1);
        load_tile(1, 0, 0);
        load_tile(2, 0, 2);
        load_tile(0, 1, 0);
        load_tile(1, 1, 1);
        load_tile(2, 1, 255);
        query_pixel(0, 0);
        query_pixel(4, 4);
        query_pixel(3, 3);
        query_pixel(11, 7);
        query_pixel(9, 2);
        query_pixel(12, 0);
        query_pixel(0, 8);
        query_pixel(16383, 16383);
        drain();

        // Directed: the largest pixel scale with two subsamples.
        write_settings(2, 2, 128, 2, 7, 9, 7);
        fill_map();
        query_pixel(63, 64);
        query_pixel(255, 255);
        drain();

        // Random phases, with gaps on both sides in most of them.
        items = 0;
        while (requests_sent < 1400) begin
            idle_on = $urandom_range(0, 3) != 0;
            case ($urandom_range(0, 19))
                0: begin w = 128; h = 1; end
                1: begin w = 1; h = 128; end
                default: begin w = $urandom_range(1, 8); h = $urandom_range(1, 8); end
            endcase
            s = 2 << $urandom_range(0, 4);
            n = ($urandom_range(0, 3) == 0) ? 2 : 1;
            if ($urandom_range(0, 29) == 0) n = 4;
            if ($urandom_range(0, 14) == 0) s = 6;
            if ($urandom_range(0, 2) == 0)
                write_settings(w, h, s, n, 0, 1, 2);
            else
                write_settings(w, h, s, n, $urandom_range(0, 255), $urandom_range(0, 255),
                               $urandom_range(0, 255));
            fill_map();
            if (items == 0) hold_go = 1'b1;
            for (int k = $urandom_range(20, 80); k > 0; k--) begin
                if ($urandom_range(0, 2) == 0)
                    load_tile($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                              pick_category());
                else
                    random_query();
            end
            items++;
            drain();
        end

        i_in_valid <= 1'b0;
        while (checker_h.pending_alpha_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (checker_h.mismatches == 0 && checker_h.pending_alpha_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Generous bound on the whole run.
    initial begin
        #400_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> water_coverage_alpha_rasterizer_top.f
src/wcar_pkg.sv
src/wcar_ram.sv
src/wcar_feather.sv
src/water_coverage_alpha_rasterizer_top.sv
tb/tb_top.sv
